FILE: sv/srs_pkg.sv
// Shared types, widths and codes for the setpoint ramp sequencer.
// Used by every module of the block but srs_ram; depends on nothing.
package srs_pkg;

   localparam int CHANNELS    = 16;
   localparam int QUEUE_DEPTH = 64;
   localparam int TIME_W      = 40;
   localparam int VAL_W       = 32;
   localparam int CH_W        = 4;
   localparam int KIND_W      = 3;
   localparam int MASK_W      = 16;
   localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int CIDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CCNT_W      = CIDX_W + 1;
   localparam int ADDR_W      = CIDX_W + SLOT_W;
   localparam int STORE_DEPTH = CHANNELS * QUEUE_DEPTH;
   localparam int ENTRY_W     = TIME_W + VAL_W;
   localparam int MAG_W       = VAL_W + 1;
   localparam int PROD_W      = TIME_W + MAG_W;
   localparam int MD_CNT_W    = $clog2(MAG_W + 1);
   localparam int FIFO_DEPTH  = 2;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ORDER    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OUTPUT   = 3'd4;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_LOAD,
      OP_TICK
   } op_type;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [CH_W-1:0]         channel;
      logic [TIME_W-1:0]       item_time;
      logic signed [VAL_W-1:0] setpoint_value;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]       result_kind;
      logic [CH_W-1:0]         out_channel;
      logic signed [VAL_W-1:0] out_value;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      op_type                  op;
      logic [CH_W-1:0]         channel;
      logic [TIME_W-1:0]       item_time;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

FILE: sv/srs_ram.sv
// Generic single write, single read RAM with registered read data.
// No package dependency.
module srs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/srs_front.sv
// Front end: takes request beats, classifies them and hands commands on.
// Depends on srs_pkg.
module srs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  srs_pkg::req_item_type req_data,
   output logic                 req_stall,
   input  srs_pkg::fifo_status_type fifo_status,
   output logic                 push,
   output srs_pkg::cmd_type     push_data
);

   logic                  hold_valid_ff, hold_valid_in;
   srs_pkg::req_item_type hold_ff;
   logic                  is_cmd;
   srs_pkg::op_type       op;
   logic                  accept;

   assign req_stall = hold_valid_ff && fifo_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      is_cmd = 1'b1;
      op     = srs_pkg::OP_TICK;
      unique case (hold_ff.req_type)
         srs_pkg::REQ_CLEAR: op = srs_pkg::OP_CLEAR;
         srs_pkg::REQ_LOAD:  op = srs_pkg::OP_LOAD;
         srs_pkg::REQ_TICK:  op = srs_pkg::OP_TICK;
         default:            is_cmd = 1'b0;
      endcase
   end

   // drop unused request codes as they leave the holding register
   assign push = hold_valid_ff && !fifo_status.full && is_cmd;
   assign push_data = '{op: op, channel: hold_ff.channel, item_time: hold_ff.item_time,
                        value: hold_ff.setpoint_value};

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (hold_valid_ff && !fifo_status.full) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      if (accept) begin
         hold_ff <= req_data;
      end
   end

endmodule

FILE: sv/srs_fifo.sv
// Short command queue between the front end and the executing back end.
// Depends on srs_pkg.
module srs_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  srs_pkg::cmd_type push_data,
   input  logic             pop,
   output srs_pkg::cmd_type pop_data,
   output srs_pkg::fifo_status_type status
);

   localparam int PTR_W = $clog2(srs_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(srs_pkg::FIFO_DEPTH + 1);

   srs_pkg::cmd_type mem_ff [srs_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = p + 1'b1;
      if (p == PTR_W'(srs_pkg::FIFO_DEPTH - 1)) begin
         r = '0;
      end
      return r;
   endfunction

   assign status.full  = (cnt_ff == CNT_W'(srs_pkg::FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/srs_muldiv.sv
// Serial unit for floor(el * mag / span): shift-add multiply, then restoring divide.
// Depends on srs_pkg.
module srs_muldiv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [srs_pkg::TIME_W-1:0]    el,
   input  logic [srs_pkg::MAG_W-1:0]     mag,
   input  logic [srs_pkg::TIME_W-1:0]    span,
   output logic                          busy,
   output logic                          done,
   output logic [srs_pkg::MAG_W-1:0]     quotient
);

   localparam int TW = srs_pkg::TIME_W;
   localparam int MW = srs_pkg::MAG_W;
   localparam int PW = srs_pkg::PROD_W;
   localparam int CW = srs_pkg::MD_CNT_W;

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_type;

   md_state_type   state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [PW-1:0]  acc_ff, acc_in;
   logic [TW-1:0]  el_ff, el_in, span_ff, span_in, rem_ff, rem_in;
   logic [MW-1:0]  mag_ff, mag_in, q_ff, q_in;
   logic           done_ff, done_in;
   logic [TW:0]    trial;
   logic [TW:0]    shifted;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      el_in    = el_ff;
      span_in  = span_ff;
      rem_in   = rem_ff;
      mag_in   = mag_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff, acc_ff[MW-1]};
      trial    = shifted - {1'b0, span_ff};
      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               el_in    = el;
               mag_in   = mag;
               span_in  = span;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            // multiplier bits enter MSB first
            acc_in = {acc_ff[PW-2:0], 1'b0} + (mag_ff[MW-1] ? PW'(el_ff) : '0);
            mag_in = {mag_ff[MW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MW - 1)) begin
               cnt_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            // upper product bits are already below span
            if (cnt_ff == '0) begin
               shifted = {acc_ff[PW-1:MW], acc_ff[MW-1]};
               trial   = shifted - {1'b0, span_ff};
            end
            if (!trial[TW]) begin
               rem_in = trial[TW-1:0];
               q_in   = {q_ff[MW-2:0], 1'b1};
            end else begin
               rem_in = shifted[TW-1:0];
               q_in   = {q_ff[MW-2:0], 1'b0};
            end
            acc_in = {acc_ff[PW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MW - 1)) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      el_ff   <= el_in;
      span_ff <= span_in;
      rem_ff  <= rem_in;
      mag_ff  <= mag_in;
      q_ff    <= q_in;
   end

   assign busy     = (state_ff != MD_IDLE);
   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: sv/srs_back.sv
// Back end: executes clear, load and tick commands against the setpoint store.
// Depends on srs_pkg, srs_ram and srs_muldiv.
module srs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  srs_pkg::fifo_status_type   fifo_status,
   input  srs_pkg::cmd_type           fifo_data,
   output logic                       fifo_pop,
   input  logic [srs_pkg::MASK_W-1:0] mode_mask,
   output logic                       rsp_valid,
   output srs_pkg::rsp_item_type      rsp_data,
   input  logic                       rsp_stall
);

   localparam int SW = srs_pkg::SLOT_W;
   localparam int NW = srs_pkg::COUNT_W;
   localparam int IW = srs_pkg::CIDX_W;
   localparam int KW = srs_pkg::CCNT_W;
   localparam int TW = srs_pkg::TIME_W;
   localparam int VW = srs_pkg::VAL_W;
   localparam int MW = srs_pkg::MAG_W;
   localparam int NCH = srs_pkg::CHANNELS;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_LOAD, S_LOAD_CMP, S_CHAN, S_HEAD, S_NEXT, S_DIV, S_PUSH, S_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   srs_pkg::cmd_type      cmd_ff, cmd_in;
   logic [KW-1:0]         chan_ff, chan_in;
   logic [SW-1:0]         head_ff [NCH];
   logic [SW-1:0]         head_in [NCH];
   logic [NW-1:0]         count_ff [NCH];
   logic [NW-1:0]         count_in [NCH];
   logic [TW-1:0]         t0_ff, t0_in;
   logic signed [VW-1:0]  v0_ff, v0_in;
   logic                  neg_ff, neg_in;
   srs_pkg::rsp_item_type res_ff, res_in, pend_ff, pend_in, rsp_ff, rsp_in;
   logic                  pend_valid_ff, pend_valid_in, rsp_valid_ff, rsp_valid_in;

   logic                          ram_we;
   logic [srs_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [srs_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
   logic [TW-1:0]                 rd_time;
   logic signed [VW-1:0]          rd_value;

   logic                  md_start, md_busy, md_done;
   logic [TW-1:0]         md_el, md_span;
   logic [MW-1:0]         md_mag, md_q;

   logic                  out_free;
   logic [IW-1:0]         cidx, lidx;
   logic                  ch_ok, linear;
   logic [NW-1:0]         sel_count;
   logic [SW-1:0]         sel_head;
   logic signed [MW:0]    diff, ramp;

   function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] h, input logic [NW-1:0] k);
      logic [NW:0] s;
      s = (NW + 1)'(h) + (NW + 1)'(k);
      if (s >= (NW + 1)'(srs_pkg::QUEUE_DEPTH)) begin
         s = s - (NW + 1)'(srs_pkg::QUEUE_DEPTH);
      end
      return s[SW-1:0];
   endfunction

   srs_ram #(.WIDTH(srs_pkg::ENTRY_W), .DEPTH(srs_pkg::STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   srs_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .el       (md_el),
      .mag      (md_mag),
      .span     (md_span),
      .busy     (md_busy),
      .done     (md_done),
      .quotient (md_q)
   );

   assign rd_time   = ram_rdata[srs_pkg::ENTRY_W-1:VW];
   assign rd_value  = ram_rdata[VW-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cidx      = chan_ff[IW-1:0];
   assign lidx      = IW'(cmd_ff.channel);
   assign ch_ok     = (32'(cmd_ff.channel) < NCH);
   assign sel_count = ch_ok ? count_ff[lidx] : '0;
   assign sel_head  = ch_ok ? head_ff[lidx] : '0;
   assign ram_waddr = {lidx, slot_add(sel_head, sel_count)};
   assign ram_wdata = {cmd_ff.item_time, cmd_ff.value};
   assign diff      = (MW + 1)'(rd_value) - (MW + 1)'(v0_ff);
   assign md_el     = cmd_ff.item_time - t0_ff;
   assign md_span   = rd_time - t0_ff;
   assign md_mag    = diff[MW] ? MW'(-diff) : diff[MW-1:0];
   assign ramp      = neg_ff ? (MW + 1)'(v0_ff) - (MW + 1)'(md_q)
                             : (MW + 1)'(v0_ff) + (MW + 1)'(md_q);

   always_comb begin
      linear = 1'b0;
      for (int i = 0; i < srs_pkg::MASK_W; i++) begin
         if (32'(chan_ff) == i) begin
            linear = mode_mask[i];
         end
      end
   end

   always_comb begin
      unique case (state_ff)
         S_LOAD, S_LOAD_CMP: ram_raddr = {lidx, slot_add(sel_head, sel_count - 1'b1)};
         S_CHAN:             ram_raddr = {cidx, head_ff[cidx]};
         S_HEAD, S_NEXT:     ram_raddr = {cidx, slot_add(head_ff[cidx], NW'(1))};
         default:            ram_raddr = {cidx, head_ff[cidx]};
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      chan_in       = chan_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      t0_in         = t0_ff;
      v0_in         = v0_ff;
      neg_in        = neg_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      fifo_pop      = 1'b0;
      ram_we        = 1'b0;
      md_start      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!fifo_status.empty) begin
               fifo_pop = 1'b1;
               cmd_in   = fifo_data;
               chan_in  = '0;
               unique case (fifo_data.op)
                  srs_pkg::OP_CLEAR: state_in = S_CLEAR;
                  srs_pkg::OP_LOAD:  state_in = S_LOAD;
                  srs_pkg::OP_TICK:  state_in = S_CHAN;
                  default:           state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            if (out_free) begin
               for (int c = 0; c < NCH; c++) begin
                  head_in[c]  = '0;
                  count_in[c] = '0;
               end
               rsp_in       = '{result_kind: srs_pkg::KIND_CLEARED, out_channel: '0,
                                out_value: '0, last: 1'b1};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LOAD: begin
            if (!ch_ok || sel_count >= NW'(srs_pkg::QUEUE_DEPTH)) begin
               if (out_free) begin
                  rsp_in       = '{result_kind: srs_pkg::KIND_FULL,
                                   out_channel: cmd_ff.channel,
                                   out_value: cmd_ff.value, last: 1'b1};
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (sel_count == '0) begin
               if (out_free) begin
                  ram_we         = 1'b1;
                  count_in[lidx] = sel_count + 1'b1;
                  rsp_in         = '{result_kind: srs_pkg::KIND_ACCEPTED,
                                     out_channel: cmd_ff.channel,
                                     out_value: cmd_ff.value, last: 1'b1};
                  rsp_valid_in   = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               state_in = S_LOAD_CMP;
            end
         end
         S_LOAD_CMP: begin
            // tail read address is held, so the read data stays valid while stalled
            if (out_free) begin
               rsp_in = '{result_kind: srs_pkg::KIND_ORDER, out_channel: cmd_ff.channel,
                          out_value: cmd_ff.value, last: 1'b1};
               if (cmd_ff.item_time > rd_time) begin
                  ram_we             = 1'b1;
                  count_in[lidx]     = sel_count + 1'b1;
                  rsp_in.result_kind = srs_pkg::KIND_ACCEPTED;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_CHAN: begin
            if (chan_ff == KW'(NCH)) begin
               state_in = S_FLUSH;
            end else if (count_ff[cidx] == '0) begin
               chan_in = chan_ff + 1'b1;
            end else begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            t0_in  = rd_time;
            v0_in  = rd_value;
            res_in = '{result_kind: srs_pkg::KIND_OUTPUT, out_channel: srs_pkg::CH_W'(chan_ff),
                       out_value: rd_value, last: 1'b0};
            if (cmd_ff.item_time < rd_time) begin
               chan_in  = chan_ff + 1'b1;
               state_in = S_CHAN;
            end else if (!linear || count_ff[cidx] == NW'(1)) begin
               head_in[cidx]  = slot_add(head_ff[cidx], NW'(1));
               count_in[cidx] = count_ff[cidx] - 1'b1;
               state_in       = S_PUSH;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            res_in.out_value = rd_value;
            if (cmd_ff.item_time >= rd_time) begin
               head_in[cidx]  = slot_add(head_ff[cidx], NW'(1));
               count_in[cidx] = count_ff[cidx] - 1'b1;
               state_in       = S_PUSH;
            end else begin
               neg_in   = diff[MW];
               md_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (md_done) begin
               res_in.out_value = ramp[VW-1:0];
               state_in         = S_PUSH;
            end
         end
         S_PUSH: begin
            // hold one result back so the final one of the tick can carry last
            if (!pend_valid_ff) begin
               pend_in       = res_ff;
               pend_valid_in = 1'b1;
               chan_in       = chan_ff + 1'b1;
               state_in      = S_CHAN;
            end else if (out_free) begin
               rsp_in        = pend_ff;
               rsp_valid_in  = 1'b1;
               pend_in       = res_ff;
               chan_in       = chan_ff + 1'b1;
               state_in      = S_CHAN;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < NCH; c++) begin
            head_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
      end
      cmd_ff  <= cmd_in;
      chan_ff <= chan_in;
      t0_ff   <= t0_in;
      v0_ff   <= v0_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_md_start_idle: assert property (@(posedge clock) disable iff (reset)
      md_start |-> !md_busy)
      else $error("ramp divider started while busy");
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("tick result left pending at idle");
   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ch_ok && sel_count < NW'(srs_pkg::QUEUE_DEPTH)))
      else $error("setpoint written into a full queue");
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == S_DIV))
      else $error("divider result arrived outside the divide wait");
`endif

endmodule

FILE: sv/setpoint_ramp_sequencer_top.sv
// Top level of the setpoint ramp sequencer: mode register, front end, queue, back end.
// Depends on srs_pkg, srs_front, srs_fifo and srs_back.
//
//   channel  | direction | handshake          | payload
//   req_     | in        | req_valid/stall    | srs_pkg::req_item_type
//   rsp_     | out       | rsp_valid/stall    | srs_pkg::rsp_item_type
//   csr_     | in        | csr_valid/ready    | linear mode mask, 16 bits
//
// A tick walks the channels in turn; an empty channel is skipped, and an interpolating
// channel runs the serial multiply (33 steps) and restoring divide (33 steps) of the
// ramp unit; a channel that waits, steps or advances does not use the ramp unit.
// Reset is synchronous and clears queue heads and counts at once; stored setpoints
// are not cleared. A stalled result holds the back end; the front end keeps taking
// beats until its holding register and the two-entry command queue are full.
module setpoint_ramp_sequencer_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  srs_pkg::req_item_type      req_data,
   output logic                       req_stall,
   output logic                       rsp_valid,
   output srs_pkg::rsp_item_type      rsp_data,
   input  logic                       rsp_stall,
   input  logic                       csr_valid,
   input  logic [srs_pkg::MASK_W-1:0] csr_data,
   output logic                       csr_ready
);

   logic [srs_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic                       push, pop;
   srs_pkg::cmd_type           push_data, pop_data;
   srs_pkg::fifo_status_type   fifo_status;

   assign csr_ready = 1'b1;
   assign mask_in   = (csr_valid && csr_ready) ? csr_data : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   srs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .fifo_status (fifo_status),
      .push        (push),
      .push_data   (push_data)
   );

   srs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   srs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .fifo_data   (pop_data),
      .fifo_pop    (pop),
      .mode_mask   (mask_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

endmodule
